@@ rtl/spi_master_shift_engine_defines.svh @@
// ----------------------------------------------------------------------------
// spi master shift engine assertion macros
// concurrent checks clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_SHIFT_ENGINE_DEFINES_SVH
`define SPI_MASTER_SHIFT_ENGINE_DEFINES_SVH

// property must hold at every rising clock edge out of reset
`define SPSE_ASSERT(lbl_, prop_) \
  lbl_: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop_)) \
    else $error("spse check failed");

// expression must never be true out of reset
`define SPSE_ASSERT_NEVER(lbl_, expr_) \
  lbl_: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr_)) \
    else $error("spse forbidden condition");

`endif

@@ rtl/spse_pkg.sv @@
// ----------------------------------------------------------------------------
// spse_pkg
// shared types and constants of the spi master shift engine
// ----------------------------------------------------------------------------
package spse_pkg;

  localparam int MaxFrameBits = 16;
  localparam int BitsW        = $clog2(MaxFrameBits + 1);
  localparam int IdxW         = $clog2(MaxFrameBits);
  localparam int WordW        = 16;
  localparam int ModeW        = 2;
  localparam int FrameW       = 5;
  localparam int HalfW        = 16;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 16;
  localparam int QueueDepth   = 2;

  localparam logic [FrameW-1:0] FrameBitsRst = 5'd8;
  localparam logic [HalfW-1:0]  HalfRst      = 16'd5;

  typedef enum logic {
    OpStart = 1'b0,
    OpTick  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpiMode    = 2'd0,
    CfgFrameBits  = 2'd1,
    CfgHalfPeriod = 2'd2
  } cfg_reg_e;

  typedef logic [MaxFrameBits-1:0] shift_t;

  typedef struct packed {
    logic             is_start;
    logic [WordW-1:0] tx_word;
    logic             miso;
  } cmd_t;

  typedef struct packed {
    logic [ModeW-1:0]  spi_mode;
    logic [FrameW-1:0] frame_bits;
    logic [HalfW-1:0]  half_period;
  } cfg_t;

  typedef struct packed {
    logic             sclk;
    logic             mosi;
    logic             cs_n;
    logic             busy;
    logic             done;
    logic [WordW-1:0] rx_word;
  } res_t;

endpackage

@@ rtl/spse_if.sv @@
// ----------------------------------------------------------------------------
// spse channel interfaces
// valid/ready channels for input words and result words
// ----------------------------------------------------------------------------
interface spse_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [spse_pkg::WordW-1:0] tx_word;
  logic                       miso_level;

  modport source (output valid, op, tx_word, miso_level, input ready);
  modport sink   (input valid, op, tx_word, miso_level, output ready);
endinterface

interface spse_out_if;
  logic                       valid;
  logic                       ready;
  logic                       sclk_level;
  logic                       mosi_level;
  logic                       cs_n_level;
  logic                       busy_flag;
  logic                       frame_done;
  logic [spse_pkg::WordW-1:0] rx_word;

  modport source (output valid, sclk_level, mosi_level, cs_n_level, busy_flag,
                  frame_done, rx_word, input ready);
  modport sink   (input valid, sclk_level, mosi_level, cs_n_level, busy_flag,
                  frame_done, rx_word, output ready);
endinterface

@@ rtl/spse_front.sv @@
// ----------------------------------------------------------------------------
// spse_front
// registers incoming words and classifies them as frame start or tick
// ----------------------------------------------------------------------------
module spse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  spse_in_if.sink         in_i,
  output logic            push_o,
  output spse_pkg::cmd_t  cmd_o,
  input  logic            push_ready_i
);

  logic           valid_q, valid_d;
  spse_pkg::cmd_t cmd_q, cmd_d;
  logic           accept;

  assign in_i.ready = !valid_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = valid_q;
  assign cmd_o      = cmd_q;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (accept) begin
      valid_d          = 1'b1;
      cmd_d.is_start   = (in_i.op == spse_pkg::OpStart);
      cmd_d.tx_word    = in_i.tx_word;
      cmd_d.miso       = in_i.miso_level;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

@@ rtl/spse_queue.sv @@
// ----------------------------------------------------------------------------
// spse_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module spse_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spse_pkg::cmd_t  cmd_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output spse_pkg::cmd_t  cmd_o,
  input  logic            pop_i
);

  localparam int Depth  = spse_pkg::QueueDepth;
  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  spse_pkg::cmd_t    mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != CountW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign cmd_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/spse_back.sv @@
// ----------------------------------------------------------------------------
// spse_back
// runs the spi frame state per word and holds the result word register
// ----------------------------------------------------------------------------
`include "spi_master_shift_engine_defines.svh"

module spse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spse_pkg::cfg_t  cfg_i,
  input  logic            cmd_valid_i,
  input  spse_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  spse_out_if.source      out_o
);

  localparam int Mfb   = spse_pkg::MaxFrameBits;
  localparam int BitsW = spse_pkg::BitsW;
  localparam int IdxW  = spse_pkg::IdxW;
  localparam int HalfW = spse_pkg::HalfW;

  spse_pkg::shift_t   tx_q, tx_d, rx_q, rx_d;
  logic [BitsW-1:0]   bits_q, bits_d;
  logic [HalfW-1:0]   tick_q, tick_d;
  logic               second_q, second_d;
  logic               active_q, active_d;
  logic               sclk_q, sclk_d;
  logic               dout_q, dout_d;
  logic               out_valid_q, out_valid_d;
  spse_pkg::res_t     res_q, res_d;

  logic               pop;
  logic               done;
  logic               cpol, cpha;
  logic [BitsW-1:0]   n_bits;
  logic [BitsW-1:0]   bits_dec;
  logic [IdxW-1:0]    top_idx;
  logic [HalfW-1:0]   hp, tick_inc;
  spse_pkg::shift_t   mask, ones, load_val, tx_shifted, rx_shifted;
  logic [31:0]        tx_wide, rx_wide;

  assign pop   = cmd_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = pop;
  assign cpol  = cfg_i.spi_mode[1];
  assign cpha  = cfg_i.spi_mode[0];

  // frame length saturated to the supported range
  always_comb begin
    if (cfg_i.frame_bits == '0) begin
      n_bits = BitsW'(1);
    end else if (32'(cfg_i.frame_bits) > Mfb) begin
      n_bits = BitsW'(Mfb);
    end else begin
      n_bits = BitsW'(cfg_i.frame_bits);
    end
  end

  assign top_idx    = IdxW'(n_bits - 1'b1);
  assign ones       = '1;
  assign mask       = ~(ones << n_bits);
  assign hp         = (cfg_i.half_period == '0) ? HalfW'(1) : cfg_i.half_period;
  assign tick_inc   = tick_q + 1'b1;
  assign tx_wide    = 32'(cmd_i.tx_word);
  assign load_val   = tx_wide[Mfb-1:0] & mask;
  assign tx_shifted = (tx_q << 1) & mask;
  assign rx_shifted = ((rx_q << 1) | spse_pkg::shift_t'(cmd_i.miso)) & mask;

  always_comb begin
    tx_d     = tx_q;
    rx_d     = rx_q;
    bits_d   = bits_q;
    tick_d   = tick_q;
    second_d = second_q;
    active_d = active_q;
    sclk_d   = sclk_q;
    dout_d   = dout_q;
    done     = 1'b0;
    bits_dec = bits_q;
    if (pop) begin
      if (cmd_i.is_start) begin
        // a start during a frame is dropped
        if (!active_q) begin
          active_d = 1'b1;
          tx_d     = load_val;
          rx_d     = '0;
          bits_d   = n_bits;
          tick_d   = '0;
          second_d = 1'b0;
          sclk_d   = cpol;
          if (!cpha) begin
            dout_d = load_val[top_idx];
          end
        end
      end else if (!active_q) begin
        sclk_d = cpol;
      end else begin
        tick_d = tick_inc;
        if (tick_inc >= hp) begin
          tick_d = '0;
          if (!second_q) begin
            // leading edge
            sclk_d = ~cpol;
            if (!cpha) begin
              rx_d = rx_shifted;
            end else begin
              dout_d = tx_q[top_idx];
              tx_d   = tx_shifted;
            end
            second_d = 1'b1;
          end else begin
            // trailing edge
            sclk_d = cpol;
            if (!cpha) begin
              tx_d = tx_shifted;
            end else begin
              rx_d = rx_shifted;
            end
            if (bits_q != '0) begin
              bits_dec = bits_q - 1'b1;
            end
            bits_d = bits_dec;
            if (!cpha && bits_dec != '0) begin
              dout_d = tx_shifted[top_idx];
            end
            second_d = 1'b0;
            if (bits_dec == '0) begin
              active_d = 1'b0;
              done     = 1'b1;
            end
          end
        end
      end
    end
  end

  assign rx_wide = 32'(rx_d);

  always_comb begin
    out_valid_d   = out_valid_q;
    res_d         = res_q;
    if (pop) begin
      out_valid_d   = 1'b1;
      res_d.sclk    = sclk_d;
      res_d.mosi    = dout_d;
      res_d.cs_n    = ~active_d;
      res_d.busy    = active_d;
      res_d.done    = done;
      res_d.rx_word = done ? rx_wide[spse_pkg::WordW-1:0] : '0;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q        <= '0;
      rx_q        <= '0;
      bits_q      <= '0;
      tick_q      <= '0;
      second_q    <= 1'b0;
      active_q    <= 1'b0;
      sclk_q      <= 1'b0;
      dout_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tx_q        <= tx_d;
      rx_q        <= rx_d;
      bits_q      <= bits_d;
      tick_q      <= tick_d;
      second_q    <= second_d;
      active_q    <= active_d;
      sclk_q      <= sclk_d;
      dout_q      <= dout_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sclk_level = res_q.sclk;
  assign out_o.mosi_level = res_q.mosi;
  assign out_o.cs_n_level = res_q.cs_n;
  assign out_o.busy_flag  = res_q.busy;
  assign out_o.frame_done = res_q.done;
  assign out_o.rx_word    = res_q.rx_word;

  `SPSE_ASSERT(a_active_has_bits, active_q |-> (bits_q != '0))
  `SPSE_ASSERT(a_idle_timer_clear, !active_q |-> ((tick_q == '0) && !second_q))
  `SPSE_ASSERT(a_done_ends_frame, (pop && done) |=> (!active_q && out_valid_q && res_q.done))
  `SPSE_ASSERT_NEVER(a_done_while_busy, out_valid_q && res_q.done && res_q.busy)

endmodule

@@ rtl/spi_master_shift_engine.sv @@
// ----------------------------------------------------------------------------
// spi_master_shift_engine
// spi master, modes 0 to 3, msb first, driven by start and tick words
// ----------------------------------------------------------------------------
// channel  | dir | content
// in_i     | in  | op, tx_word, miso_level
// out_o    | out | sclk_level, mosi_level, cs_n_level, busy_flag, frame_done, rx_word
// cfg_*    | in  | spi_mode, frame_bits, half_period_ticks register writes
//
// one word per clock sustained while out_o does not stall; a word passes the input
// register, the fifo and the result register on its way to out_o
// the frame state updates as a word leaves the fifo
// out_o stalls fill the two-entry fifo before in_i.ready drops
// rst_ni clears all control state asynchronously; no clearing pass
// ----------------------------------------------------------------------------
module spi_master_shift_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  spse_in_if.sink                       in_i,
  spse_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [spse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spse_pkg::CfgDataW-1:0] cfg_data_i
);

  spse_pkg::cfg_t cfg_q, cfg_d;
  logic           push, push_ready, q_valid, pop;
  spse_pkg::cmd_t front_cmd, q_cmd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spse_pkg::CfgSpiMode:    cfg_d.spi_mode    = cfg_data_i[spse_pkg::ModeW-1:0];
        spse_pkg::CfgFrameBits:  cfg_d.frame_bits  = cfg_data_i[spse_pkg::FrameW-1:0];
        spse_pkg::CfgHalfPeriod: cfg_d.half_period = cfg_data_i[spse_pkg::HalfW-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spi_mode    <= '0;
      cfg_q.frame_bits  <= spse_pkg::FrameBitsRst;
      cfg_q.half_period <= spse_pkg::HalfRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  spse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .cmd_o        (front_cmd),
    .push_ready_i (push_ready)
  );

  spse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (front_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .cmd_o        (q_cmd),
    .pop_i        (pop)
  );

  spse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// streams start and tick words into the spi master shift engine under random
// stalls, predicts each result word from a cycle-free model of the shifter and
// pins, and checks the results in order, field by field
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit  = 100000;
  localparam int DrainCycles = 8;
  localparam int RandomWords = 1250;
  localparam int HoldCycles  = 150;

  localparam int WordW        = spse_pkg::WordW;
  localparam int ModeW        = spse_pkg::ModeW;
  localparam int FrameW       = spse_pkg::FrameW;
  localparam int HalfW        = spse_pkg::HalfW;
  localparam int BitsW        = spse_pkg::BitsW;
  localparam int CfgDataW     = spse_pkg::CfgDataW;
  localparam int MaxFrameBits = spse_pkg::MaxFrameBits;

  typedef struct packed {
    spse_pkg::op_e    op;
    logic [WordW-1:0] tx_word;
    logic             miso;
  } spi_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  spse_pkg::cfg_reg_e  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  spse_in_if  in_if ();
  spse_out_if out_if ();

  spi_master_shift_engine DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // register copies as the shifter sees them
  logic [ModeW-1:0]  cfg_mode;
  logic [FrameW-1:0] cfg_frame_bits;
  logic [HalfW-1:0]  cfg_half;

  // shifter and pin state
  spse_pkg::shift_t  sr_tx;
  spse_pkg::shift_t  sr_rx;
  logic [BitsW-1:0]  bits_rem;
  logic [HalfW-1:0]  tick_cnt;
  logic              trailing_next;
  logic              in_frame;
  logic              sclk_pin;
  logic              mosi_pin;

  spi_word_t      pending_words[$];
  spse_pkg::res_t expected_pins[$];
  spi_word_t      held_word;
  spse_pkg::res_t exp_r;
  int unsigned    fail_cnt = 0;
  int unsigned    cycle_cnt = 0;
  int unsigned    queued_words = 0;
  int unsigned    burst_left = 1;
  int unsigned    gap_left = 0;
  int unsigned    hold_cycles = 0;
  logic           hold_done = 1'b0;
  int unsigned    pat_kind = 0;
  int unsigned    pat_left = 0;

  function automatic int unsigned frame_len(logic [FrameW-1:0] fb);
    if (fb == 0) return 1;
    if (fb > MaxFrameBits) return MaxFrameBits;
    return 32'(fb);
  endfunction

  function automatic int unsigned half_len(logic [HalfW-1:0] h);
    return (h == 0) ? 1 : 32'(h);
  endfunction

  // advances the shifter by one word and returns the pins it reports
  function automatic spse_pkg::res_t spi_pin_step(spi_word_t w);
    logic             cpol;
    logic             cpha;
    int unsigned      nb;
    spse_pkg::shift_t mask;
    spse_pkg::res_t   r;
    cpol = cfg_mode[1];
    cpha = cfg_mode[0];
    nb   = frame_len(cfg_frame_bits);
    mask = spse_pkg::shift_t'((32'd1 << nb) - 32'd1);
    r    = '0;
    if (w.op == spse_pkg::OpStart) begin
      // a start during a frame leaves everything alone
      if (!in_frame) begin
        in_frame      = 1'b1;
        sr_tx         = w.tx_word & mask;
        sr_rx         = '0;
        bits_rem      = BitsW'(nb);
        tick_cnt      = '0;
        trailing_next = 1'b0;
        sclk_pin      = cpol;
        if (!cpha) mosi_pin = sr_tx[nb-1];
      end
    end else if (!in_frame) begin
      sclk_pin = cpol;
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= half_len(cfg_half)) begin
        tick_cnt = '0;
        if (!trailing_next) begin
          sclk_pin = ~cpol;
          if (!cpha) begin
            sr_rx = ((sr_rx << 1) | spse_pkg::shift_t'(w.miso)) & mask;
          end else begin
            mosi_pin = sr_tx[nb-1];
            sr_tx    = (sr_tx << 1) & mask;
          end
          trailing_next = 1'b1;
        end else begin
          sclk_pin = cpol;
          if (!cpha) sr_tx = (sr_tx << 1) & mask;
          else sr_rx = ((sr_rx << 1) | spse_pkg::shift_t'(w.miso)) & mask;
          if (bits_rem != 0) bits_rem = bits_rem - 1'b1;
          if (!cpha && bits_rem != 0) mosi_pin = sr_tx[nb-1];
          trailing_next = 1'b0;
          if (bits_rem == 0) begin
            in_frame  = 1'b0;
            r.done    = 1'b1;
            r.rx_word = sr_rx;
          end
        end
      end
    end
    r.sclk = sclk_pin;
    r.mosi = mosi_pin;
    r.cs_n = ~in_frame;
    r.busy = in_frame;
    return r;
  endfunction

  task automatic check_field(string name, logic [WordW-1:0] exp_v, logic [WordW-1:0] got);
    if (got !== exp_v) begin
      $error("%s expected %0h got %0h", name, exp_v, got);
      fail_cnt++;
    end
  endtask

  task automatic push_word(spse_pkg::op_e op, logic [WordW-1:0] tx, logic miso);
    spi_word_t w;
    w.op      = op;
    w.tx_word = tx;
    w.miso    = miso;
    pending_words.push_back(w);
    queued_words++;
  endtask

  task automatic write_reg(spse_pkg::cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    unique case (idx)
      spse_pkg::CfgSpiMode:    cfg_mode = val[ModeW-1:0];
      spse_pkg::CfgFrameBits:  cfg_frame_bits = val[FrameW-1:0];
      spse_pkg::CfgHalfPeriod: cfg_half = val;
      default: ;
    endcase
  endtask

  // pipeline empty and every result word seen
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_if.valid || expected_pins.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.op         <= spse_pkg::OpTick;
      in_if.tx_word    <= '0;
      in_if.miso_level <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) expected_pins.push_back(spi_pin_step(held_word));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          held_word = pending_words.pop_front();
          in_if.valid      <= 1'b1;
          in_if.op         <= held_word.op;
          in_if.tx_word    <= held_word.tx_word;
          in_if.miso_level <= held_word.miso;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: switching stall patterns and one long hold-off while words queue up
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles--;
      out_if.ready <= 1'b0;
    end else if (rst_ni && !hold_done && pending_words.size() > 40) begin
      hold_done   = 1'b1;
      hold_cycles = HoldCycles;
      out_if.ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_kind = $urandom_range(0, 3);
        pat_left = $urandom_range(32, 256);
      end else begin
        pat_left--;
      end
      unique case (pat_kind)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= ($urandom_range(0, 9) != 0);
        default: out_if.ready <= (cycle_cnt % 5) != 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_pins.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
      end else begin
        exp_r = expected_pins.pop_front();
        check_field("sclk_level", WordW'(exp_r.sclk), WordW'(out_if.sclk_level));
        check_field("mosi_level", WordW'(exp_r.mosi), WordW'(out_if.mosi_level));
        check_field("cs_n_level", WordW'(exp_r.cs_n), WordW'(out_if.cs_n_level));
        check_field("busy_flag", WordW'(exp_r.busy), WordW'(out_if.busy_flag));
        check_field("frame_done", WordW'(exp_r.done), WordW'(out_if.frame_done));
        check_field("rx_word", exp_r.rx_word, out_if.rx_word);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned nb;
    int unsigned hl;
    int unsigned ticks;
    int unsigned pick;
    logic [FrameW-1:0] fb;
    logic [HalfW-1:0]  hp;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = spse_pkg::CfgSpiMode;
    cfg_data_i       = '0;
    rst_ni           = 1'b0;
    cfg_mode         = '0;
    cfg_frame_bits   = spse_pkg::FrameBitsRst;
    cfg_half         = spse_pkg::HalfRst;
    sr_tx            = '0;
    sr_rx            = '0;
    bits_rem         = '0;
    tick_cnt         = '0;
    trailing_next    = 1'b0;
    in_frame         = 1'b0;
    sclk_pin         = 1'b0;
    mosi_pin         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // idle tick under reset settings
    push_word(spse_pkg::OpTick, 16'h0000, 1'b1);
    wait_quiet();

    // zero frame length and zero half period both clamp to one
    write_reg(spse_pkg::CfgSpiMode, 16'd0);
    write_reg(spse_pkg::CfgFrameBits, 16'd0);
    write_reg(spse_pkg::CfgHalfPeriod, 16'd0);
    @(negedge clk_i);
    push_word(spse_pkg::OpTick, 16'h0000, 1'b1);
    push_word(spse_pkg::OpStart, 16'hFFFF, 1'b0);
    push_word(spse_pkg::OpStart, 16'h0000, 1'b1);
    push_word(spse_pkg::OpTick, 16'h0000, 1'b1);
    push_word(spse_pkg::OpTick, 16'h0000, 1'b0);
    wait_quiet();

    write_reg(spse_pkg::CfgSpiMode, 16'd3);
    @(negedge clk_i);
    push_word(spse_pkg::OpTick, 16'h0000, 1'b0);
    push_word(spse_pkg::OpStart, 16'h0000, 1'b1);
    push_word(spse_pkg::OpTick, 16'hFFFF, 1'b1);
    push_word(spse_pkg::OpTick, 16'h0000, 1'b1);
    wait_quiet();

    // oversized frame length, slowest clock
    write_reg(spse_pkg::CfgSpiMode, 16'd2);
    write_reg(spse_pkg::CfgFrameBits, 16'd31);
    write_reg(spse_pkg::CfgHalfPeriod, 16'hFFFF);
    @(negedge clk_i);
    push_word(spse_pkg::OpStart, 16'hFFFF, 1'b0);
    repeat (3) push_word(spse_pkg::OpTick, 16'h0000, 1'b1);
    wait_quiet();

    // settings changed mid-frame: tick count already past the new half period
    write_reg(spse_pkg::CfgHalfPeriod, 16'd1);
    write_reg(spse_pkg::CfgSpiMode, 16'd1);
    @(negedge clk_i);
    push_word(spse_pkg::OpTick, 16'h0000, 1'b1);
    push_word(spse_pkg::OpTick, 16'h0000, 1'b0);
    push_word(spse_pkg::OpStart, 16'h1234, 1'b1);
    push_word(spse_pkg::OpTick, 16'h0000, 1'b1);
    push_word(spse_pkg::OpTick, 16'h0000, 1'b0);
    wait_quiet();

    queued_words = 0;
    while (queued_words < RandomWords) begin
      write_reg(spse_pkg::CfgSpiMode, 16'($urandom_range(0, 3)));
      pick = $urandom_range(0, 9);
      fb = (pick < 4) ? 5'd8 : (pick < 8) ? 5'd16 : 5'($urandom_range(0, 31));
      write_reg(spse_pkg::CfgFrameBits, 16'(fb));
      pick = $urandom_range(0, 19);
      hp = (pick == 0) ? 16'd0 :
           (pick == 1) ? 16'($urandom_range(4, 65535)) : 16'($urandom_range(1, 3));
      write_reg(spse_pkg::CfgHalfPeriod, hp);
      nb = frame_len(fb);
      hl = half_len(hp);
      @(negedge clk_i);
      if (hl > 3) begin
        // slow clock, so a frame may not finish: a start and a few ticks
        push_word(spse_pkg::OpStart, 16'($urandom()), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(5, 30))
          push_word(spse_pkg::OpTick, 16'($urandom()), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_word(spse_pkg::OpStart, 16'($urandom()), 1'($urandom_range(0, 1)));
          ticks = 2 * nb * hl + $urandom_range(0, 3);
          // some frames cut short so the next settings land mid-frame
          if ($urandom_range(0, 9) == 0) ticks = $urandom_range(1, ticks);
          repeat (ticks) begin
            if ($urandom_range(0, 19) == 0)
              push_word(spse_pkg::OpStart, 16'($urandom()), 1'($urandom_range(0, 1)));
            push_word(spse_pkg::OpTick, 16'($urandom()), 1'($urandom_range(0, 1)));
          end
        end
      end
      wait_quiet();
    end

    if (fail_cnt == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/spse_pkg.sv
rtl/spse_if.sv
rtl/spse_front.sv
rtl/spse_queue.sv
rtl/spse_back.sv
rtl/spi_master_shift_engine.sv
tb/tb_top.sv
